@@ rtl/core/dna_pkg.sv @@
// Shared types, codes and saturation helper for the dual number ALU.
package dna_pkg;

  typedef enum logic [2:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_MUL = 3'd2,
    CMD_DIV = 3'd3,
    CMD_ABS = 3'd4
  } cmd_e;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIV0 = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  localparam int unsigned QW = 32;
  localparam int unsigned VW = 32;
  localparam int unsigned DW = 64;
  localparam int unsigned PIPE_EDGES = QW + 5;

  localparam logic [31:0] POS_LIM = 32'h7fff_ffff;
  localparam logic [31:0] NEG_LIM = 32'h8000_0000;

  typedef struct packed {
    logic [31:0] val;
    logic        sat;
  } sat_t;

  typedef struct packed {
    logic        is_div;
    logic        b_zero;
    logic        neg_v;
    logic        neg_d;
    logic        q_neg;
    logic        ovf_v;
    logic        ovf_d;
    logic [31:0] rv;
    logic [31:0] rd;
    logic [1:0]  st;
  } side_t;

  function automatic sat_t sat32(input logic neg, input logic [63:0] mag);
    sat_t r;
    r.sat = 1'b0;
    if (neg) begin
      if (mag > 64'h0000_0000_8000_0000) begin
        r.val = NEG_LIM;
        r.sat = 1'b1;
      end else begin
        r.val = 32'd0 - mag[31:0];
      end
    end else if (mag > 64'h0000_0000_7fff_ffff) begin
      r.val = POS_LIM;
      r.sat = 1'b1;
    end else begin
      r.val = mag[31:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/core/dna_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, value and derivative side by side.
module dna_div import dna_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  side_t         side_i,
  input  logic [VW-1:0] num_v_hi_i,
  input  logic [QW-1:0] num_v_lo_i,
  input  logic [VW-1:0] den_v_i,
  input  logic [DW-1:0] num_d_hi_i,
  input  logic [QW-1:0] num_d_lo_i,
  input  logic [DW-1:0] den_d_i,
  output logic          valid_o,
  output side_t         side_o,
  output logic [QW-1:0] quo_v_o,
  output logic [QW-1:0] quo_d_o
);

  logic [QW:0]   vld;
  side_t         side  [QW+1];
  logic [VW-1:0] rem_v [QW+1];
  logic [QW-1:0] lo_v  [QW+1];
  logic [VW-1:0] den_v [QW+1];
  logic [QW-1:0] q_v   [QW+1];
  logic [DW-1:0] rem_d [QW+1];
  logic [QW-1:0] lo_d  [QW+1];
  logic [DW-1:0] den_d [QW+1];
  logic [QW-1:0] q_d   [QW+1];

  assign vld[0]   = valid_i;
  assign side[0]  = side_i;
  assign rem_v[0] = num_v_hi_i;
  assign lo_v[0]  = num_v_lo_i;
  assign den_v[0] = den_v_i;
  assign q_v[0]   = '0;
  assign rem_d[0] = num_d_hi_i;
  assign lo_d[0]  = num_d_lo_i;
  assign den_d[0] = den_d_i;
  assign q_d[0]   = '0;

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [VW:0]   tv;
    logic [DW:0]   td;
    logic          ge_v;
    logic          ge_d;
    logic [VW-1:0] nrv;
    logic [DW-1:0] nrd;

    always_comb begin
      tv   = {rem_v[k], lo_v[k][QW-1]};
      td   = {rem_d[k], lo_d[k][QW-1]};
      ge_v = tv >= {1'b0, den_v[k]};
      ge_d = td >= {1'b0, den_d[k]};
      nrv  = ge_v ? VW'(tv - {1'b0, den_v[k]}) : tv[VW-1:0];
      nrd  = ge_d ? DW'(td - {1'b0, den_d[k]}) : td[DW-1:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk_i) begin
      side[k+1]  <= side[k];
      rem_v[k+1] <= nrv;
      lo_v[k+1]  <= {lo_v[k][QW-2:0], 1'b0};
      den_v[k+1] <= den_v[k];
      q_v[k+1]   <= {q_v[k][QW-2:0], ge_v};
      rem_d[k+1] <= nrd;
      lo_d[k+1]  <= {lo_d[k][QW-2:0], 1'b0};
      den_d[k+1] <= den_d[k];
      q_d[k+1]   <= {q_d[k][QW-2:0], ge_d};
    end
  end

  assign valid_o = vld[QW];
  assign side_o  = side[QW];
  assign quo_v_o = q_v[QW];
  assign quo_d_o = q_d[QW];

endmodule

@@ rtl/core/dual_number_alu.sv @@
// Dual number ALU top level: products, sums, magnitudes, divider pipeline and output word.
// done_o rises for every command once the word has passed the front stages, the divider and the output register.
// Throughput: one word per cycle; busy_o stays low and the receiver cannot stall.
// Depth is set by the 32-stage divider plus four front stages and the output register.
// Reset clears all valid bits at once; payload registers are not reset.
module dual_number_alu import dna_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [2:0]         cmd_i,
  input  logic signed [31:0] a_val_i,
  input  logic signed [31:0] a_der_i,
  input  logic signed [31:0] b_val_i,
  input  logic signed [31:0] b_der_i,
  output logic               done_o,
  output logic signed [31:0] r_val_o,
  output logic signed [31:0] r_der_o,
  output logic [1:0]         status_o
);

  localparam int unsigned SH = 32 - FRAC_BITS;

  // stage 1: products
  logic               s1_vld_q;
  logic [2:0]         s1_cmd_q;
  logic signed [31:0] s1_av_q, s1_ad_q, s1_bv_q, s1_bd_q;
  logic signed [63:0] s1_pvv_q, s1_pdb_q, s1_pad_q, s1_pbb_q;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_cmd_q <= cmd_i;
    s1_av_q  <= a_val_i;
    s1_ad_q  <= a_der_i;
    s1_bv_q  <= b_val_i;
    s1_bd_q  <= b_der_i;
    s1_pvv_q <= a_val_i * b_val_i;
    s1_pdb_q <= a_der_i * b_val_i;
    s1_pad_q <= a_val_i * b_der_i;
    s1_pbb_q <= b_val_i * b_val_i;
  end

  // stage 2: sums and selection
  logic signed [64:0] s2_wv_d, s2_wd_d;
  logic               s2_vld_q, s2_isdiv_q, s2_ismul_q, s2_aneg_q;
  logic signed [64:0] s2_wv_q, s2_wd_q;
  logic signed [31:0] s2_bv_q;
  logic [63:0]        s2_bb_q;

  always_comb begin
    s2_wv_d = '0;
    s2_wd_d = '0;
    case (s1_cmd_q)
      CMD_ADD: begin
        s2_wv_d = 65'(s1_av_q) + 65'(s1_bv_q);
        s2_wd_d = 65'(s1_ad_q) + 65'(s1_bd_q);
      end
      CMD_SUB: begin
        s2_wv_d = 65'(s1_av_q) - 65'(s1_bv_q);
        s2_wd_d = 65'(s1_ad_q) - 65'(s1_bd_q);
      end
      CMD_MUL: begin
        s2_wv_d = 65'(s1_pvv_q);
        s2_wd_d = 65'(s1_pdb_q) + 65'(s1_pad_q);
      end
      CMD_DIV: begin
        s2_wv_d = 65'(s1_av_q);
        s2_wd_d = 65'(s1_pdb_q) - 65'(s1_pad_q);
      end
      CMD_ABS: begin
        s2_wv_d = s1_av_q[31] ? -65'(s1_av_q) : 65'(s1_av_q);
        if (s1_av_q[31]) begin
          s2_wd_d = -65'(s1_ad_q);
        end else if (s1_av_q != 32'sd0) begin
          s2_wd_d = 65'(s1_ad_q);
        end
      end
      default: begin
        s2_wv_d = '0;
        s2_wd_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_wv_q    <= s2_wv_d;
    s2_wd_q    <= s2_wd_d;
    s2_isdiv_q <= (s1_cmd_q == CMD_DIV);
    s2_ismul_q <= (s1_cmd_q == CMD_MUL);
    s2_aneg_q  <= s1_av_q[31];
    s2_bv_q    <= s1_bv_q;
    s2_bb_q    <= 64'(s1_pbb_q);
  end

  // stage 3: magnitudes
  logic        s3_vld_q, s3_isdiv_q, s3_ismul_q, s3_negv_q, s3_negd_q;
  logic        s3_bzero_q, s3_qneg_q;
  logic [63:0] s3_magv_q, s3_magd_q, s3_bb_q;
  logic [31:0] s3_bmag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_isdiv_q <= s2_isdiv_q;
    s3_ismul_q <= s2_ismul_q;
    s3_negv_q  <= s2_wv_q[64];
    s3_negd_q  <= s2_wd_q[64];
    s3_magv_q  <= s2_wv_q[64] ? 64'(-s2_wv_q) : s2_wv_q[63:0];
    s3_magd_q  <= s2_wd_q[64] ? 64'(-s2_wd_q) : s2_wd_q[63:0];
    s3_bmag_q  <= s2_bv_q[31] ? 32'(-s2_bv_q) : 32'(s2_bv_q);
    s3_bzero_q <= (s2_bv_q == 32'sd0);
    s3_qneg_q  <= s2_aneg_q ^ s2_bv_q[31];
    s3_bb_q    <= s2_bb_q;
  end

  // stage 4: saturation of direct results, overflow check, divider operands
  sat_t          s4_satv, s4_satd;
  side_t         s4_side_d, s4_side_q;
  logic          s4_vld_q;
  logic [VW-1:0] s4_nvh_q, s4_dv_q;
  logic [QW-1:0] s4_nvl_q, s4_ndl_q;
  logic [DW-1:0] s4_ndh_q, s4_dd_q;

  always_comb begin
    s4_satv = sat32(s3_negv_q, s3_ismul_q ? (s3_magv_q >> FRAC_BITS) : s3_magv_q);
    s4_satd = sat32(s3_negd_q, s3_ismul_q ? (s3_magd_q >> FRAC_BITS) : s3_magd_q);
    s4_side_d.is_div = s3_isdiv_q;
    s4_side_d.b_zero = s3_bzero_q;
    s4_side_d.neg_v  = s3_negv_q;
    s4_side_d.neg_d  = s3_negd_q;
    s4_side_d.q_neg  = s3_qneg_q;
    s4_side_d.ovf_v  = {32'd0, s3_magv_q[31:0]} >= ({32'd0, s3_bmag_q} << SH);
    s4_side_d.ovf_d  = {32'd0, s3_magd_q} >= ({32'd0, s3_bb_q} << SH);
    s4_side_d.rv     = s4_satv.val;
    s4_side_d.rd     = s4_satd.val;
    s4_side_d.st     = (s4_satv.sat || s4_satd.sat) ? ST_SAT : ST_OK;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q <= 1'b0;
    end else begin
      s4_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s4_side_q <= s4_side_d;
    s4_nvh_q  <= VW'(s3_magv_q[31:0] >> SH);
    s4_nvl_q  <= s3_magv_q[31:0] << FRAC_BITS;
    s4_dv_q   <= s3_bmag_q;
    s4_ndh_q  <= s3_magd_q >> SH;
    s4_ndl_q  <= s3_magd_q[31:0] << FRAC_BITS;
    s4_dd_q   <= s3_bb_q;
  end

  // divider
  logic          dv_vld;
  side_t         dv_side;
  logic [QW-1:0] dv_qv, dv_qd;

  dna_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (s4_vld_q),
    .side_i     (s4_side_q),
    .num_v_hi_i (s4_nvh_q),
    .num_v_lo_i (s4_nvl_q),
    .den_v_i    (s4_dv_q),
    .num_d_hi_i (s4_ndh_q),
    .num_d_lo_i (s4_ndl_q),
    .den_d_i    (s4_dd_q),
    .valid_o    (dv_vld),
    .side_o     (dv_side),
    .quo_v_o    (dv_qv),
    .quo_d_o    (dv_qd)
  );

  // output word
  sat_t        fq_v, fq_d;
  logic [31:0] r_val_d, r_der_d;
  logic [1:0]  status_d;
  logic        done_q;
  logic [31:0] r_val_q, r_der_q;
  logic [1:0]  status_q;

  always_comb begin
    fq_v = sat32(dv_side.q_neg, dv_side.ovf_v ? 64'h1_0000_0000 : {32'd0, dv_qv});
    fq_d = sat32(dv_side.neg_d, dv_side.ovf_d ? 64'h1_0000_0000 : {32'd0, dv_qd});
    if (!dv_side.is_div) begin
      r_val_d  = dv_side.rv;
      r_der_d  = dv_side.rd;
      status_d = dv_side.st;
    end else if (dv_side.b_zero) begin
      r_val_d  = dv_side.neg_v ? NEG_LIM : POS_LIM;
      r_der_d  = dv_side.neg_d ? NEG_LIM : POS_LIM;
      status_d = ST_DIV0;
    end else begin
      r_val_d  = fq_v.val;
      r_der_d  = fq_d.val;
      status_d = (fq_v.sat || fq_d.sat) ? ST_SAT : ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    r_val_q  <= r_val_d;
    r_der_q  <= r_der_d;
    status_q <= status_d;
  end

  assign done_o   = done_q;
  assign r_val_o  = signed'(r_val_q);
  assign r_der_o  = signed'(r_der_q);
  assign status_o = status_q;

endmodule

@@ rtl/core/dna_checker.sv @@
// Port-level checks on the dual number ALU and their binding to the top level.
module dna_checker import dna_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input logic [2:0]         cmd_i,
  input logic signed [31:0] b_val_i,
  input logic               done_o,
  input logic signed [31:0] r_val_o,
  input logic [1:0]         status_o
);

  localparam int unsigned CW = $clog2(PIPE_EDGES + 1);

  logic [CW-1:0] warm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      warm_q <= '0;
    end else if (warm_q != CW'(PIPE_EDGES)) begin
      warm_q <= warm_q + 1'b1;
    end
  end

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o == ST_OK || status_o == ST_DIV0 || status_o == ST_SAT))
    else $error("undefined status code");

  a_one_per_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (warm_q == CW'(PIPE_EDGES)) |-> (done_o == $past(start_i && !busy_o, PIPE_EDGES)))
    else $error("result strobe does not match accepted word");

  a_div0_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (warm_q == CW'(PIPE_EDGES)) && done_o |->
      ((status_o == ST_DIV0) ==
       $past(cmd_i == CMD_DIV && b_val_i == 32'sd0, PIPE_EDGES)))
    else $error("divide-by-zero status on wrong word");

  a_div0_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o == ST_DIV0) |->
      (r_val_o == signed'(POS_LIM) || r_val_o == signed'(NEG_LIM)))
    else $error("divide-by-zero value not at a limit");

endmodule

bind dual_number_alu dna_checker u_dna_checker (.*);

@@ test/tb_top.sv @@
// Self-checking testbench for the dual number ALU: directed corners, then random bursts.
module tb_top;
  import dna_pkg::*;

  localparam int FB        = 16;
  localparam int N_RANDOM  = 1600;
  localparam int DRAIN     = 45;
  localparam int WATCH_LIM = 4000;

  typedef struct {
    logic [31:0] r_val;
    logic [31:0] r_der;
    logic [1:0]  status;
  } dual_word_t;

  class dual_scoreboard;
    dual_word_t pending[$];
    int         errors;

    function new();
      errors = 0;
    endfunction

    function automatic logic [31:0] clamp32(input logic signed [127:0] x, inout bit sat);
      if (x > 128'sh7fff_ffff) begin
        sat = 1'b1;
        return POS_LIM;
      end
      if (x < -128'sh8000_0000) begin
        sat = 1'b1;
        return NEG_LIM;
      end
      return x[31:0];
    endfunction

    // truncate toward zero, dropping the fraction bits of a product
    function automatic logic signed [127:0] trunc_q(input logic signed [127:0] x);
      if (x < 0) return -((-x) >>> FB);
      return x >>> FB;
    endfunction

    function automatic dual_word_t eval_dual(input logic [2:0] cmd,
                                             input logic signed [31:0] av,
                                             input logic signed [31:0] ad,
                                             input logic signed [31:0] bv,
                                             input logic signed [31:0] bd);
      dual_word_t w;
      logic signed [127:0] xav, xad, xbv, xbd, num;
      logic [127:0] mag_a, mag_b, mag_n, q;
      bit sat;
      xav = av;
      xad = ad;
      xbv = bv;
      xbd = bd;
      sat = 1'b0;
      w.r_val = '0;
      w.r_der = '0;
      w.status = ST_OK;
      case (cmd)
        CMD_ADD: begin
          w.r_val = clamp32(xav + xbv, sat);
          w.r_der = clamp32(xad + xbd, sat);
        end
        CMD_SUB: begin
          w.r_val = clamp32(xav - xbv, sat);
          w.r_der = clamp32(xad - xbd, sat);
        end
        CMD_MUL: begin
          w.r_val = clamp32(trunc_q(xav * xbv), sat);
          w.r_der = clamp32(trunc_q(xad * xbv + xav * xbd), sat);
        end
        CMD_DIV: begin
          num = xad * xbv - xav * xbd;
          if (bv == 0) begin
            w.r_val = (av < 0) ? NEG_LIM : POS_LIM;
            w.r_der = (num < 0) ? NEG_LIM : POS_LIM;
            w.status = ST_DIV0;
          end else begin
            mag_a = (xav < 0) ? -xav : xav;
            mag_b = (xbv < 0) ? -xbv : xbv;
            mag_n = (num < 0) ? -num : num;
            q = (mag_a << FB) / mag_b;
            w.r_val = clamp32(((av < 0) != (bv < 0)) ? -$signed(q) : $signed(q), sat);
            q = (mag_n << FB) / (mag_b * mag_b);
            w.r_der = clamp32((num < 0) ? -$signed(q) : $signed(q), sat);
          end
        end
        CMD_ABS: begin
          w.r_val = clamp32((xav < 0) ? -xav : xav, sat);
          if (av > 0) w.r_der = clamp32(xad, sat);
          else if (av < 0) w.r_der = clamp32(-xad, sat);
        end
        default: ;
      endcase
      if (w.status == ST_OK && sat) w.status = ST_SAT;
      return w;
    endfunction

    function void note_word(input logic [2:0] cmd, input logic [31:0] av, ad, bv, bd);
      pending.push_back(eval_dual(cmd, av, ad, bv, bd));
    endfunction

    function void check_word(input logic [31:0] rv, rd, input logic [1:0] st);
      dual_word_t e;
      if (pending.size() == 0) begin
        $error("unexpected result word r_val=%h r_der=%h status=%0d", rv, rd, st);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (rv !== e.r_val) begin
        $error("r_val: expected %h, actual %h", e.r_val, rv);
        errors++;
      end
      if (rd !== e.r_der) begin
        $error("r_der: expected %h, actual %h", e.r_der, rd);
        errors++;
      end
      if (st !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, st);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [2:0]  cmd_i = '0;
  logic signed [31:0] a_val_i = '0, a_der_i = '0, b_val_i = '0, b_der_i = '0;
  logic        done_o;
  logic signed [31:0] r_val_o, r_der_o;
  logic [1:0]  status_o;

  dual_scoreboard sb = new();
  int idle_cycles = 0;

  always #4 clk_i = ~clk_i;

  dual_number_alu #(.FRAC_BITS(FB)) u_dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .cmd_i,
    .a_val_i, .a_der_i, .b_val_i, .b_der_i,
    .done_o, .r_val_o, .r_der_o, .status_o
  );

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) sb.note_word(cmd_i, a_val_i, a_der_i, b_val_i, b_der_i);
      if (done_o) sb.check_word(r_val_o, r_der_o, status_o);
      if ((start_i && !busy_o) || done_o) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles > WATCH_LIM) begin
      $display("dual_number_alu test failed");
      $finish;
    end
  end

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return $urandom_range(0, 3) == 0 ? 32'h8000_0000 : 32'h7fff_ffff;
      1:       return 32'($signed($urandom_range(0, 4)) - 2);
      2:       return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hffff_0000;
      3, 4:    return 32'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
      default: return $urandom;
    endcase
  endfunction

  // hold the word on the ports until the block takes it
  task automatic send_word(input logic [2:0] cmd, input logic [31:0] av, ad, bv, bd);
    start_i <= 1'b1;
    cmd_i   <= cmd;
    a_val_i <= av;
    a_der_i <= ad;
    b_val_i <= bv;
    b_der_i <= bd;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic pause_sender(input int n);
    start_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  initial begin
    int sent;
    int burst;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_word(CMD_ADD, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 32'hffff_ffff);
    send_word(CMD_ADD, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    send_word(CMD_ADD, 32'h0001_8000, 32'hfffe_0000, 32'h0000_8000, 32'h0002_0000);
    send_word(CMD_SUB, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001, 32'hffff_ffff);
    send_word(CMD_SUB, 32'h0003_0000, 32'h0000_0000, 32'h0001_0000, 32'h0000_0000);
    send_word(CMD_MUL, 32'h0002_0000, 32'h0001_0000, 32'h0003_0000, 32'h0000_8000);
    send_word(CMD_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_word(CMD_MUL, 32'hffff_ffff, 32'h0000_0001, 32'h0000_0001, 32'hffff_ffff);
    send_word(CMD_MUL, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    send_word(CMD_DIV, 32'h0006_0000, 32'h0001_0000, 32'h0002_0000, 32'h0001_0000);
    send_word(CMD_DIV, 32'hfffa_0000, 32'h0000_0000, 32'h0004_0000, 32'hffff_0000);
    send_word(CMD_DIV, 32'h0005_0000, 32'h0001_0000, 32'h0000_0000, 32'h0001_0000);
    send_word(CMD_DIV, 32'hfffb_0000, 32'h0001_0000, 32'h0000_0000, 32'h0001_0000);
    send_word(CMD_DIV, 32'h0000_0000, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000);
    send_word(CMD_DIV, 32'h7fff_ffff, 32'h7fff_ffff, 32'h0000_0001, 32'h8000_0000);
    send_word(CMD_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
    send_word(CMD_DIV, 32'h0000_0001, 32'h0000_0001, 32'hffff_ffff, 32'h0000_0001);
    send_word(CMD_ABS, 32'h8000_0000, 32'h0001_0000, 32'h1234_5678, 32'h9abc_def0);
    send_word(CMD_ABS, 32'hffff_0000, 32'h8000_0000, 32'h0, 32'h0);
    send_word(CMD_ABS, 32'h0000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_word(CMD_ABS, 32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h0);
    send_word(CMD_ABS, 32'hffff_ffff, 32'h7fff_ffff, 32'h0, 32'h0);
    pause_sender(3);

    sent = 0;
    while (sent < N_RANDOM) begin
      burst = $urandom_range(0, 3) == 0 ? $urandom_range(30, 80) : $urandom_range(1, 12);
      repeat (burst) begin
        logic [31:0] bv;
        bv = ($urandom_range(0, 15) == 0) ? 32'h0 : pick_word();
        send_word(3'($urandom_range(CMD_ADD, CMD_ABS)), pick_word(), pick_word(), bv,
                  pick_word());
        sent++;
      end
      if (sent > N_RANDOM / 2 && sent - burst <= N_RANDOM / 2) begin
        start_i <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk_i);
      end else if ($urandom_range(0, 2) != 0) begin
        pause_sender($urandom_range(1, 20));
      end
    end
    start_i <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("dual_number_alu test passed");
    end else begin
      $display("dual_number_alu test failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/dna_pkg.sv
rtl/core/dna_div.sv
rtl/core/dual_number_alu.sv
rtl/core/dna_checker.sv
test/tb_top.sv
